FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_CLASSES = 4;

  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CLS_IDX_W = $clog2(NUM_CLASSES);
  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // fixed field widths
  localparam int CLASS_ID_W = 3;
  localparam int HANDLE_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int SERVED_W   = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_QOS_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ENABLE = 1'b1;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ     = 3'd0,
    ST_DEQ     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_INVALID = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  // decision for one command, from the scheduler to the store
  typedef struct packed {
    status_e               status;
    logic [CLS_IDX_W-1:0]  cls;
    logic                  we;
    logic                  re;
    logic [ADDR_W-1:0]     addr;
  } dec_t;

  // result waiting in the output stage
  typedef struct packed {
    status_e               status;
    logic [CLS_IDX_W-1:0]  cls;
  } res_t;

endpackage

FILE: sv/spq_if.sv
`timescale 1ns / 1ps

interface spq_cmd_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [spq_pkg::CLASS_ID_W-1:0]  class_id;
  logic [spq_pkg::HANDLE_W-1:0]    packet_handle;
  logic                            station_blocked;

  modport source (output valid, cmd, class_id, packet_handle, station_blocked,
                  input ready);
  modport sink (input valid, cmd, class_id, packet_handle, station_blocked,
                output ready);
endinterface

interface spq_res_if;
  logic                            valid;
  logic                            ready;
  logic [spq_pkg::STATUS_W-1:0]    status;
  logic                            packet_valid;
  logic [spq_pkg::HANDLE_W-1:0]    out_handle;
  logic [spq_pkg::SERVED_W-1:0]    served_class;

  modport source (output valid, status, packet_valid, out_handle, served_class,
                  input ready);
  modport sink (input valid, status, packet_valid, out_handle, served_class,
                output ready);
endinterface

FILE: sv/spq_sched.sv
`timescale 1ns / 1ps

module spq_sched (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic                            cmd_i,
  input  logic [spq_pkg::CLASS_ID_W-1:0]  class_id_i,
  input  logic                            blocked_i,
  input  logic                            qos_i,
  input  logic                            blk_i,
  output spq_pkg::dec_t                   dec_o
);

  localparam logic [spq_pkg::CLS_IDX_W-1:0] HI_CLS =
    spq_pkg::CLS_IDX_W'(spq_pkg::NUM_CLASSES - 1);

  logic [spq_pkg::PTR_W-1:0] head_q [spq_pkg::NUM_CLASSES];
  logic [spq_pkg::PTR_W-1:0] tail_q [spq_pkg::NUM_CLASSES];
  logic [spq_pkg::OCC_W-1:0] occ_q  [spq_pkg::NUM_CLASSES];

  function automatic logic [spq_pkg::PTR_W-1:0] advance(
    input logic [spq_pkg::PTR_W-1:0] p
  );
    logic [spq_pkg::PTR_W:0] nxt;
    nxt = {1'b0, p} + 1'b1;
    if (nxt >= (spq_pkg::PTR_W+1)'(spq_pkg::QUEUE_DEPTH)) begin
      return '0;
    end
    return nxt[spq_pkg::PTR_W-1:0];
  endfunction

  function automatic logic [spq_pkg::ADDR_W-1:0] mem_addr(
    input logic [spq_pkg::CLS_IDX_W-1:0] c,
    input logic [spq_pkg::PTR_W-1:0]     p
  );
    return spq_pkg::ADDR_W'(c) * spq_pkg::ADDR_W'(spq_pkg::QUEUE_DEPTH)
         + spq_pkg::ADDR_W'(p);
  endfunction

  always_comb begin
    spq_pkg::dec_t d;
    logic          found;
    d      = '0;
    d.status = spq_pkg::ST_EMPTY;
    found  = 1'b0;
    if (cmd_i == spq_pkg::CMD_ENQ) begin
      if (qos_i && ({1'b0, class_id_i} >=
                    (spq_pkg::CLASS_ID_W+1)'(spq_pkg::NUM_CLASSES))) begin
        d.status = spq_pkg::ST_INVALID;
      end else begin
        d.cls = qos_i ? class_id_i[spq_pkg::CLS_IDX_W-1:0] : '0;
        if (occ_q[d.cls] >= spq_pkg::OCC_W'(spq_pkg::QUEUE_DEPTH)) begin
          d.status = spq_pkg::ST_FULL;
        end else begin
          d.status = spq_pkg::ST_ENQ;
          d.we     = 1'b1;
          d.addr   = mem_addr(d.cls, tail_q[d.cls]);
        end
      end
    end else begin
      if (!qos_i) begin
        found = (occ_q[0] != '0);
      end else begin
        // lowest non-empty class wins
        for (int i = spq_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
          if (occ_q[i] != '0) begin
            d.cls = spq_pkg::CLS_IDX_W'(i);
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        d.status = spq_pkg::ST_EMPTY;
        d.cls    = '0;
      end else if (qos_i && blk_i && blocked_i && (d.cls == HI_CLS)) begin
        d.status = spq_pkg::ST_BLOCKED;
      end else begin
        d.status = spq_pkg::ST_DEQ;
        d.re     = 1'b1;
        d.addr   = mem_addr(d.cls, head_q[d.cls]);
      end
    end
    dec_o = d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spq_pkg::NUM_CLASSES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
    end else if (fire_i) begin
      if (dec_o.we) begin
        tail_q[dec_o.cls] <= advance(tail_q[dec_o.cls]);
        occ_q[dec_o.cls]  <= occ_q[dec_o.cls] + 1'b1;
      end else if (dec_o.re) begin
        head_q[dec_o.cls] <= advance(head_q[dec_o.cls]);
        occ_q[dec_o.cls]  <= occ_q[dec_o.cls] - 1'b1;
      end
    end
  end

endmodule

FILE: sv/strict_priority_four_class_queue.sv
`timescale 1ns / 1ps

// strict-priority packet handle queue with four classes. every command
// transaction (enqueue or dequeue) yields exactly one result transaction,
// in order. a command is taken every cycle while the result side keeps up;
// the result appears in the cycle after the command is accepted, set by the
// registered read port of the handle memory (all class queues share one
// single-port-write, single-read memory of classes x depth entries). class
// pointers and fill levels sit in flops next to the memory and are updated
// in the accept cycle, so back-to-back commands see each other at once. the
// handle memory needs no clearing after reset: only written entries are ever
// read. the user writes configuration (qos enable, block enable) through
// the plain write port only while the block is idle; this is not enforced.

module strict_priority_four_class_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic                           cfg_data_i,
  spq_cmd_if.sink                        cmd_i,
  spq_res_if.source                      res_o
);

  // configuration registers
  logic qos_q;
  logic blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qos_q <= 1'b0;
      blk_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spq_pkg::CFG_QOS_ENABLE:   qos_q <= cfg_data_i;
        spq_pkg::CFG_BLOCK_ENABLE: blk_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command handshake: the output stage frees when its result is taken
  logic          fire;
  logic          res_valid_q;
  spq_pkg::res_t res_q;
  spq_pkg::dec_t dec;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign fire        = cmd_i.valid && cmd_i.ready;

  // pointer and fill-level bookkeeping, class selection
  spq_sched u_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cmd_i      (cmd_i.cmd),
    .class_id_i (cmd_i.class_id),
    .blocked_i  (cmd_i.station_blocked),
    .qos_i      (qos_q),
    .blk_i      (blk_q),
    .dec_o      (dec)
  );

  // handle memory, registered read port
  logic [spq_pkg::HANDLE_W-1:0] mem [spq_pkg::MEM_DEPTH];
  logic [spq_pkg::HANDLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (fire && dec.we) begin
      mem[dec.addr] <= cmd_i.packet_handle;
    end
    // read data holds while the result is stalled, as no command fires then
    if (fire && dec.re) begin
      rdata_q <= mem[dec.addr];
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q.status <= dec.status;
      res_q.cls    <= dec.cls;
    end
  end

  logic pkt_valid;
  assign pkt_valid = (res_q.status == spq_pkg::ST_DEQ);

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.packet_valid = pkt_valid;
  assign res_o.out_handle   = pkt_valid ? rdata_q : '0;
  assign res_o.served_class = spq_pkg::SERVED_W'(res_q.cls);

  // a handle is only shown with a dequeued result
  a_pkt_only_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.packet_valid |-> res_o.status == spq_pkg::ST_DEQ)
    else $error("handle shown without dequeue status");

  // one command never both writes and reads the memory
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> !(dec.we && dec.re))
    else $error("memory write and read from one command");

  // a memory read is always followed by its dequeue result
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && dec.re |=> res_valid_q && pkt_valid)
    else $error("memory read without dequeue result");

  // dropped invalid-class and empty results name class zero
  a_zero_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == spq_pkg::ST_INVALID ||
                    res_o.status == spq_pkg::ST_EMPTY)
      |-> res_o.served_class == '0)
    else $error("nonzero class on invalid or empty result");

endmodule
